@@ rtl/input_event_to_cursor_defines.svh @@
// Assertion macros for the input event to cursor block.
// Included by the top-level RTL file, which carries the concurrent checks; no other dependencies.
`ifndef INPUT_EVENT_TO_CURSOR_DEFINES_SVH
`define INPUT_EVENT_TO_CURSOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clk_i edge, off while rst_ni is low.
`define IEC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("iec assertion failed");
// Same check written as antecedent and consequent in the same cycle.
`define IEC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iec implication failed");
`else
`define IEC_ASSERT(lbl, prop)
`define IEC_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

@@ rtl/iec_pkg.sv @@
// Shared types, codes and helpers of the input event to cursor block.
// No dependencies; imported by iec_core and input_event_to_cursor.
package iec_pkg;

  localparam int COORD_BITS      = 12;
  localparam int SIZE_W          = COORD_BITS + 1;
  localparam int TABLET_BITS_DEF = 15;
  localparam int BTN_W           = 3;
  localparam int KEY_W           = 8;

  localparam logic [SIZE_W-1:0] DEFAULT_W = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] DEFAULT_H = SIZE_W'(768);
  localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(1 << COORD_BITS);
  localparam logic [SIZE_W-1:0] SIZE_MIN  = SIZE_W'(1);

  localparam logic [COORD_BITS-1:0] POS_X_RESET = COORD_BITS'(1024 / 2);
  localparam logic [COORD_BITS-1:0] POS_Y_RESET = COORD_BITS'(768 / 2);

  typedef enum logic [15:0] {
    EVT_SYN = 16'd0,
    EVT_KEY = 16'd1,
    EVT_REL = 16'd2,
    EVT_ABS = 16'd3
  } iec_evt_e;

  localparam logic [15:0] AXIS_X      = 16'd0;
  localparam logic [15:0] AXIS_Y      = 16'd1;
  localparam logic [15:0] SYN_REPORT  = 16'd0;
  localparam logic [15:0] CODE_LEFT   = 16'h110;
  localparam logic [15:0] CODE_RIGHT  = 16'h111;
  localparam logic [15:0] CODE_MIDDLE = 16'h112;

  localparam logic [BTN_W-1:0] BIT_LEFT   = 3'b001;
  localparam logic [BTN_W-1:0] BIT_MIDDLE = 3'b010;
  localparam logic [BTN_W-1:0] BIT_RIGHT  = 3'b100;

  typedef enum logic [0:0] {
    KIND_REPORT = 1'b0,
    KIND_KEY    = 1'b1
  } iec_kind_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } iec_cfg_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [BTN_W-1:0]      buttons;
    logic                  move_pending;
  } iec_state_t;

  typedef struct packed {
    iec_kind_e             kind;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic [BTN_W-1:0]      buttons;
    logic [KEY_W-1:0]      key_code;
    logic                  key_pressed;
  } iec_result_t;

  // Zero acts as one pixel, anything above the coordinate range is capped.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] s;
    s = raw;
    if (raw == '0) begin
      s = SIZE_MIN;
    end else if (raw > SIZE_MAX) begin
      s = SIZE_MAX;
    end
    return s;
  endfunction

endpackage

@@ rtl/iec_core.sv @@
// Event decode and cursor update for one registered event.
// Depends on iec_pkg; instantiated by input_event_to_cursor.
module iec_core import iec_pkg::*; #(
  parameter int TABLET_BITS = TABLET_BITS_DEF
) (
  input  logic [15:0]       event_type_i,
  input  logic [15:0]       event_code_i,
  input  logic [31:0]       event_value_i,
  input  logic [SIZE_W-1:0] width_i,
  input  logic [SIZE_W-1:0] height_i,
  input  iec_state_t        state_i,
  output iec_state_t        state_o,
  output logic              has_result_o,
  output iec_result_t       result_o
);

  localparam int PROD_W = TABLET_BITS + SIZE_W;
  localparam int SUM_W  = 34;
  localparam logic [TABLET_BITS-1:0] ABS_SAT_LIMIT = '1;

  logic [SIZE_W-1:0]      w_eff, h_eff, size_sel;
  logic [COORD_BITS-1:0]  pos_sel;
  logic [TABLET_BITS-1:0] abs_sat;
  logic [PROD_W-1:0]      prod;
  logic [COORD_BITS-1:0]  abs_pos;
  logic [SUM_W-1:0]       rel_sum;
  logic [COORD_BITS-1:0]  rel_pos;
  logic [SIZE_W-1:0]      size_m1;
  logic                   press;
  logic                   do_report;
  logic [BTN_W-1:0]       btn_bit;

  assign w_eff    = eff_size(width_i);
  assign h_eff    = eff_size(height_i);
  assign size_sel = (event_code_i == AXIS_Y) ? h_eff : w_eff;
  assign pos_sel  = (event_code_i == AXIS_Y) ? state_i.pos_y : state_i.pos_x;
  assign size_m1  = size_sel - SIZE_W'(1);

  // Saturate to the tablet maximum, then scale to the screen.
  assign abs_sat = (|event_value_i[31:TABLET_BITS]) ? ABS_SAT_LIMIT
                                                     : event_value_i[TABLET_BITS-1:0];
  assign prod    = {{SIZE_W{1'b0}}, abs_sat} * {{TABLET_BITS{1'b0}}, size_sel};
  assign abs_pos = prod[TABLET_BITS +: COORD_BITS];

  // Signed delta add, clamp to [0, size-1].
  assign rel_sum = {{(SUM_W-COORD_BITS){1'b0}}, pos_sel}
                 + {{(SUM_W-32){event_value_i[31]}}, event_value_i};

  always_comb begin
    if (rel_sum[SUM_W-1]) begin
      rel_pos = '0;
    end else if (rel_sum[SUM_W-2:0] >= {{(SUM_W-1-SIZE_W){1'b0}}, size_sel}) begin
      rel_pos = size_m1[COORD_BITS-1:0];
    end else begin
      rel_pos = rel_sum[COORD_BITS-1:0];
    end
  end

  assign press = |event_value_i;

  always_comb begin
    case (event_code_i)
      CODE_LEFT:   btn_bit = BIT_LEFT;
      CODE_MIDDLE: btn_bit = BIT_MIDDLE;
      CODE_RIGHT:  btn_bit = BIT_RIGHT;
      default:     btn_bit = '0;
    endcase
  end

  always_comb begin
    state_o      = state_i;
    has_result_o = 1'b0;
    do_report    = 1'b0;
    result_o     = '0;
    case (event_type_i)
      EVT_REL: begin
        if (event_code_i == AXIS_X) begin
          state_o.pos_x        = rel_pos;
          state_o.move_pending = 1'b1;
        end else if (event_code_i == AXIS_Y) begin
          state_o.pos_y        = rel_pos;
          state_o.move_pending = 1'b1;
        end
      end
      EVT_ABS: begin
        if (event_code_i == AXIS_X) begin
          state_o.pos_x = abs_pos;
        end else if (event_code_i == AXIS_Y) begin
          state_o.pos_y = abs_pos;
        end
        do_report = 1'b1;
      end
      EVT_KEY: begin
        if (btn_bit != '0) begin
          state_o.buttons = press ? (state_i.buttons | btn_bit)
                                  : (state_i.buttons & ~btn_bit);
        end else if (event_code_i[15:KEY_W] == '0) begin
          has_result_o         = 1'b1;
          result_o.kind        = KIND_KEY;
          result_o.key_code    = event_code_i[KEY_W-1:0];
          result_o.key_pressed = press;
        end
      end
      EVT_SYN: begin
        if (event_code_i == SYN_REPORT && state_i.move_pending) begin
          state_o.move_pending = 1'b0;
          do_report            = 1'b1;
        end
      end
      default: ;
    endcase
    // Report the position as it stands after this event.
    if (do_report) begin
      has_result_o      = 1'b1;
      result_o.kind     = KIND_REPORT;
      result_o.cursor_x = state_o.pos_x;
      result_o.cursor_y = state_o.pos_y;
      result_o.buttons  = state_o.buttons;
    end
  end

endmodule

@@ rtl/input_event_to_cursor.sv @@
// Top level of the input event to cursor block: input register, state, result register.
// Depends on iec_pkg, iec_core and input_event_to_cursor_defines.svh.
//
// Takes one input event per cycle while in_ready_o is high, and keeps cursor position,
// held buttons and a pending-move flag. An accepted event sits in the input register
// until it retires; there iec_core updates the state and forms at most one result.
// The result is registered in the result register as the event retires, so the input
// and result registers lie between an event's transfer and its result's transfer.
// Throughput is one event per cycle while in_ready_o is high, set by the single
// input-to-result register pass with one shared multiplier and one 34-bit add and a
// compare. A result that is not taken stalls the input only when the next event also
// produces a result; events with no result keep flowing. The user must write screen
// size through the cfg port only while the block is idle; the block does not enforce it.
`include "input_event_to_cursor_defines.svh"

module input_event_to_cursor import iec_pkg::*; #(
  parameter int TABLET_BITS = TABLET_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [SIZE_W-1:0]     cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [15:0]           event_type_i,
  input  logic [15:0]           event_code_i,
  input  logic [31:0]           event_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  result_kind_o,
  output logic [COORD_BITS-1:0] cursor_x_o,
  output logic [COORD_BITS-1:0] cursor_y_o,
  output logic [BTN_W-1:0]      button_bits_o,
  output logic [KEY_W-1:0]      key_code_o,
  output logic                  key_pressed_o
);

  localparam iec_state_t STATE_RESET = '{
    pos_x:        POS_X_RESET,
    pos_y:        POS_Y_RESET,
    buttons:      '0,
    move_pending: 1'b0
  };

  logic [SIZE_W-1:0] width_q, height_q;
  logic              s1_valid_q, s1_valid_d;
  logic [15:0]       s1_type_q, s1_code_q;
  logic [31:0]       s1_value_q;
  iec_state_t        state_q, state_d;
  logic              has_result;
  iec_result_t       result_d, out_q;
  logic              out_valid_q, out_valid_d;
  logic              out_free, proc, in_xfer;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DEFAULT_W;
      height_q <= DEFAULT_H;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  iec_core #(
    .TABLET_BITS(TABLET_BITS)
  ) u_core (
    .event_type_i (s1_type_q),
    .event_code_i (s1_code_q),
    .event_value_i(s1_value_q),
    .width_i      (width_q),
    .height_i     (height_q),
    .state_i      (state_q),
    .state_o      (state_d),
    .has_result_o (has_result),
    .result_o     (result_d)
  );

  // Retire the held event unless its result has nowhere to go.
  assign out_free   = !out_valid_q || out_ready_i;
  assign proc       = s1_valid_q && (out_free || !has_result);
  assign in_ready_o = !s1_valid_q || proc;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (proc) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (proc && has_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (proc) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_type_q  <= event_type_i;
      s1_code_q  <= event_code_i;
      s1_value_q <= event_value_i;
    end
    if (proc && has_result) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_q.kind;
  assign cursor_x_o    = out_q.cursor_x;
  assign cursor_y_o    = out_q.cursor_y;
  assign button_bits_o = out_q.buttons;
  assign key_code_o    = out_q.key_code;
  assign key_pressed_o = out_q.key_pressed;

  `IEC_ASSERT_IMPL(a_key_clean, out_valid_q && out_q.kind == KIND_KEY,
                   out_q.cursor_x == '0 && out_q.cursor_y == '0 && out_q.buttons == '0)
  `IEC_ASSERT_IMPL(a_report_clean, out_valid_q && out_q.kind == KIND_REPORT,
                   out_q.key_code == '0 && !out_q.key_pressed)
  `IEC_ASSERT_IMPL(a_stall_holds, !in_ready_o, s1_valid_q && out_valid_q && !out_ready_i)
  `IEC_ASSERT(a_sync_clears, (proc && s1_type_q == EVT_SYN && s1_code_q == SYN_REPORT)
              |=> !state_q.move_pending)
  `IEC_ASSERT(a_rel_sets, (proc && s1_type_q == EVT_REL
              && (s1_code_q == AXIS_X || s1_code_q == AXIS_Y)) |=> state_q.move_pending)

endmodule
